// ===== hw/rtl/lhsc_pkg.sv =====
`default_nettype none

package lhsc_pkg;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  localparam logic [31:0] FALLBACK_ID     = 32'd1;
  localparam logic [31:0] FALLBACK_GEN    = 32'd1;
  localparam logic [31:0] RESET_NEXT_ID   = 32'd2;
  localparam logic [31:0] RESET_NEXT_GEN  = 32'd1;

  // Search token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic        go;
    logic [63:0] key;
    logic        ok;
    logic        hit;
    logic        fb;
    logic [31:0] id;
    logic [31:0] gen;
    logic        free_found;
  } tok_t;

  // Update broadcast to every cell at the end of an item
  typedef struct packed {
    logic        clear;
    logic        promote;
    logic        write;
    logic [63:0] key;
    logic [31:0] id;
    logic [31:0] gen;
    logic        fb;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lhsc_cell.sv =====
`default_nettype none

module lhsc_cell
  import lhsc_pkg::*;
#(
  parameter int unsigned N   = 16,
  parameter int unsigned IDX = 0,
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tok_t          tok_i,
  input  wire logic [IW-1:0] hit_idx_i,
  input  wire logic [IW-1:0] hit_rank_i,
  input  wire logic [IW-1:0] free_idx_i,
  input  wire logic [IW-1:0] free_rank_i,
  input  wire logic [IW-1:0] lru_idx_i,
  output tok_t               tok_o,
  output logic [IW-1:0]      hit_idx_o,
  output logic [IW-1:0]      hit_rank_o,
  output logic [IW-1:0]      free_idx_o,
  output logic [IW-1:0]      free_rank_o,
  output logic [IW-1:0]      lru_idx_o,
  input  wire cmd_t          cmd_i,
  input  wire logic [IW-1:0] sel_idx_i,
  input  wire logic [IW-1:0] sel_rank_i
);

  localparam logic [IW-1:0] MyIdx    = IW'(IDX);
  localparam logic [IW-1:0] LastRank = IW'(N - 1);

  logic [63:0]   key_q;
  logic [31:0]   id_q;
  logic [31:0]   gen_q;
  logic          fb_q;
  logic          valid_q;
  logic [IW-1:0] rank_q;

  tok_t          tok_d;
  logic [IW-1:0] hit_idx_d, hit_rank_d, free_idx_d, free_rank_d, lru_idx_d;
  logic          match;
  logic          is_sel;

  assign match  = valid_q && (key_q == tok_i.key);
  assign is_sel = (sel_idx_i == MyIdx);

  always_comb begin
    tok_d       = tok_i;
    hit_idx_d   = hit_idx_i;
    hit_rank_d  = hit_rank_i;
    free_idx_d  = free_idx_i;
    free_rank_d = free_rank_i;
    lru_idx_d   = lru_idx_i;
    if (tok_i.go) begin
      // first matching cell wins; keys are unique anyway
      if (!tok_i.hit && match) begin
        tok_d.hit  = 1'b1;
        tok_d.fb   = fb_q;
        tok_d.id   = id_q;
        tok_d.gen  = gen_q;
        hit_idx_d  = MyIdx;
        hit_rank_d = rank_q;
      end
      if (!tok_i.free_found && !valid_q) begin
        tok_d.free_found = 1'b1;
        free_idx_d       = MyIdx;
        free_rank_d      = rank_q;
      end
      if (rank_q == LastRank) begin
        lru_idx_d = MyIdx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_o       <= '0;
      hit_idx_o   <= '0;
      hit_rank_o  <= '0;
      free_idx_o  <= '0;
      free_rank_o <= '0;
      lru_idx_o   <= '0;
    end else begin
      tok_o       <= tok_d;
      hit_idx_o   <= hit_idx_d;
      hit_rank_o  <= hit_rank_d;
      free_idx_o  <= free_idx_d;
      free_rank_o <= free_rank_d;
      lru_idx_o   <= lru_idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= MyIdx;
    end else if (cmd_i.clear) begin
      valid_q <= 1'b0;
      rank_q  <= MyIdx;
    end else if (cmd_i.promote) begin
      // move selected slot to front, shift the more recent ones back
      if (is_sel) begin
        rank_q <= '0;
      end else if (rank_q < sel_rank_i) begin
        rank_q <= rank_q + IW'(1);
      end
      if (cmd_i.write && is_sel) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!cmd_i.clear && cmd_i.write && is_sel) begin
      key_q <= cmd_i.key;
      id_q  <= cmd_i.id;
      gen_q <= cmd_i.gen;
      fb_q  <= cmd_i.fb;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lru_handle_to_shape_cache.sv =====
// Fully associative LRU cache mapping a 64-bit source handle to a shape id and
// generation, built as a chain of MAX_ENTRIES cells, each holding one entry.
// A lookup sends a search token down the chain one cell per cycle; each cell
// compares its key, notes a free slot and the least recent slot, and the
// result is committed to all cells at once. A lookup passes through every
// cell and then a commit state, a clear goes straight to commit, and one item
// is in flight at a time; a new item is taken while the previous result
// still waits in the output register. Misses hand out consecutive ids
// (from 2) and generations (from 1), wrapping at 32 bits; a failed
// conversion stores the built-in fallback shape (id 1, generation 1).
`default_nettype none

module lru_handle_to_shape_cache
  import lhsc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [63:0] source_key_i,
  input  wire logic        conversion_ok_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             hit_o,
  output logic             miss_o,
  output logic             conversion_failed_o,
  output logic             used_fallback_o,
  output logic [31:0]      shape_id_o,
  output logic [31:0]      shape_generation_o
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [IW-1:0] LastRank = IW'(MAX_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  tok_t          tok       [MAX_ENTRIES+1];
  logic [IW-1:0] hit_idx   [MAX_ENTRIES+1];
  logic [IW-1:0] hit_rank  [MAX_ENTRIES+1];
  logic [IW-1:0] free_idx  [MAX_ENTRIES+1];
  logic [IW-1:0] free_rank [MAX_ENTRIES+1];
  logic [IW-1:0] lru_idx   [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] go_vec;

  cmd_t          cmd;
  logic [IW-1:0] sel_idx, sel_rank;

  logic          pend_clear_q, pend_clear_d;
  tok_t          pend_tok_q;
  logic [IW-1:0] pend_hit_idx_q, pend_hit_rank_q, pend_free_idx_q;
  logic [IW-1:0] pend_free_rank_q, pend_lru_idx_q;

  logic [31:0] next_id_q, next_gen_q;

  logic        out_valid_q;
  logic        hit_q, miss_q, cf_q, fb_q;
  logic [31:0] id_q, gen_q;

  logic        in_xfer, commit, do_miss;
  logic [31:0] res_id, res_gen;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign commit     = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);
  assign do_miss    = !pend_clear_q && !pend_tok_q.hit;

  // launch token into the head of the chain
  always_comb begin
    tok[0]            = '0;
    tok[0].go         = in_xfer && (req_type_i == REQ_LOOKUP);
    tok[0].key        = source_key_i;
    tok[0].ok         = conversion_ok_i;
    hit_idx[0]        = '0;
    hit_rank[0]       = '0;
    free_idx[0]       = '0;
    free_rank[0]      = '0;
    lru_idx[0]        = '0;
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lhsc_cell #(
      .N   (MAX_ENTRIES),
      .IDX (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok[g]),
      .hit_idx_i   (hit_idx[g]),
      .hit_rank_i  (hit_rank[g]),
      .free_idx_i  (free_idx[g]),
      .free_rank_i (free_rank[g]),
      .lru_idx_i   (lru_idx[g]),
      .tok_o       (tok[g+1]),
      .hit_idx_o   (hit_idx[g+1]),
      .hit_rank_o  (hit_rank[g+1]),
      .free_idx_o  (free_idx[g+1]),
      .free_rank_o (free_rank[g+1]),
      .lru_idx_o   (lru_idx[g+1]),
      .cmd_i       (cmd),
      .sel_idx_i   (sel_idx),
      .sel_rank_i  (sel_rank)
    );
    assign go_vec[g] = tok[g+1].go;
  end

  // slot choice: hit slot, else lowest free slot, else least recent
  always_comb begin
    if (pend_tok_q.hit) begin
      sel_idx  = pend_hit_idx_q;
      sel_rank = pend_hit_rank_q;
    end else if (pend_tok_q.free_found) begin
      sel_idx  = pend_free_idx_q;
      sel_rank = pend_free_rank_q;
    end else begin
      sel_idx  = pend_lru_idx_q;
      sel_rank = LastRank;
    end
  end

  assign res_id  = pend_tok_q.ok ? next_id_q  : FALLBACK_ID;
  assign res_gen = pend_tok_q.ok ? next_gen_q : FALLBACK_GEN;

  always_comb begin
    cmd.clear   = commit && pend_clear_q;
    cmd.promote = commit && !pend_clear_q;
    cmd.write   = commit && do_miss;
    cmd.key     = pend_tok_q.key;
    cmd.id      = res_id;
    cmd.gen     = res_gen;
    cmd.fb      = !pend_tok_q.ok;
  end

  always_comb begin
    state_d      = state_q;
    pend_clear_d = pend_clear_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          pend_clear_d = (req_type_i == REQ_CLEAR);
          state_d      = (req_type_i == REQ_CLEAR) ? ST_COMMIT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok[MAX_ENTRIES].go) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_clear_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_clear_q <= pend_clear_d;
    end
  end

  // hold the token leaving the chain until the result can be committed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEARCH && tok[MAX_ENTRIES].go) begin
      pend_tok_q       <= tok[MAX_ENTRIES];
      pend_hit_idx_q   <= hit_idx[MAX_ENTRIES];
      pend_hit_rank_q  <= hit_rank[MAX_ENTRIES];
      pend_free_idx_q  <= free_idx[MAX_ENTRIES];
      pend_free_rank_q <= free_rank[MAX_ENTRIES];
      pend_lru_idx_q   <= lru_idx[MAX_ENTRIES];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q  <= RESET_NEXT_ID;
      next_gen_q <= RESET_NEXT_GEN;
    end else if (commit && pend_clear_q) begin
      next_id_q  <= RESET_NEXT_ID;
      next_gen_q <= RESET_NEXT_GEN;
    end else if (commit && do_miss) begin
      next_id_q  <= next_id_q + 32'd1;
      next_gen_q <= next_gen_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      if (pend_clear_q) begin
        hit_q  <= 1'b0;
        miss_q <= 1'b0;
        cf_q   <= 1'b0;
        fb_q   <= 1'b0;
        id_q   <= '0;
        gen_q  <= '0;
      end else if (pend_tok_q.hit) begin
        hit_q  <= 1'b1;
        miss_q <= 1'b0;
        cf_q   <= 1'b0;
        fb_q   <= pend_tok_q.fb;
        id_q   <= pend_tok_q.id;
        gen_q  <= pend_tok_q.gen;
      end else begin
        hit_q  <= 1'b0;
        miss_q <= 1'b1;
        cf_q   <= !pend_tok_q.ok;
        fb_q   <= !pend_tok_q.ok;
        id_q   <= res_id;
        gen_q  <= res_gen;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign hit_o               = hit_q;
  assign miss_o              = miss_q;
  assign conversion_failed_o = cf_q;
  assign used_fallback_o     = fb_q;
  assign shape_id_o          = id_q;
  assign shape_generation_o  = gen_q;

  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(go_vec))
    else $error("more than one search token in the chain");

  a_token_end_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MAX_ENTRIES].go |-> state_q == ST_SEARCH)
    else $error("search token left the chain outside a search");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_counter_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && do_miss |=> next_id_q == $past(next_id_q) + 32'd1)
    else $error("shape id counter did not advance on a miss");

endmodule

`default_nettype wire
